FILE: rtl/mrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types and codes for the multipart response reassembly tracker.
// ----------------------------------------------------------------------------
package mrr_pkg;

  // Item operation codes
  localparam logic [1:0] OP_PART    = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_BEGIN   = 2'd2;

  // Result action codes
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_ACCEPTED = 3'd1;
  localparam logic [2:0] ACT_RESEND   = 3'd2;
  localparam logic [2:0] ACT_COMPLETE = 3'd3;
  localparam logic [2:0] ACT_FAILED   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_REQUEST_ID  = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;

  localparam logic [3:0] RETRY_RESET = 4'd3;
  localparam logic [3:0] TMO_MAX     = 4'd15;

  // One part table entry
  typedef struct packed {
    logic        held;
    logic [31:0] start;
    logic [31:0] stop;
    logic [15:0] size;
  } mrr_entry_t;

  localparam int ENTRY_W = $bits(mrr_entry_t);

endpackage

FILE: rtl/mrr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/multipart_response_reassembly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multipart_response_reassembly
// Tracks one request whose reply arrives as numbered parts; reports accept,
// re-request range, completion, resend and failure.
// ----------------------------------------------------------------------------
// Channel   Ports                                   Handshake
// in_       start, busy, in_op .. in_part_bytes     start & !busy
// out_      out_valid, out_action .. out_total_size one-cycle strobe
// cfg_      cfg_valid, cfg_ready, cfg_index, cfg_data valid & ready
//
// Timeout ticks, dropped headers and items after finish are answered from idle.
// A new part is checked for a duplicate, then the contiguous parts from zero
// are scanned, then entries are searched for the later bound; scan and search
// visit each entry at most once, one read at a time through the single read
// port of the part table.
// Begin and reset run a clearing pass over every entry of the table.
// Results cannot be stalled; one result per item.
// ----------------------------------------------------------------------------
module multipart_response_reassembly #(
  parameter int MAX_PARTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic        in_parse_ok,
  input  logic        in_name_ok,
  input  logic [30:0] in_packet_id,
  input  logic [15:0] in_part_index,
  input  logic [15:0] in_part_last,
  input  logic [31:0] in_start_offset,
  input  logic [31:0] in_stop_offset,
  input  logic [15:0] in_part_bytes,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [5:0]  out_accepted_part,
  output logic        out_request_rewritten,
  output logic [6:0]  out_from_part,
  output logic [31:0] out_from_byte,
  output logic        out_end_valid,
  output logic [31:0] out_end_byte,
  output logic [31:0] out_total_start,
  output logic [31:0] out_total_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW = $clog2(MAX_PARTS + 2);
  localparam logic [IW-1:0] CLR_LAST = IW'(MAX_PARTS - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_PARTS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_DUP    = 4'd2;
  localparam logic [3:0] S_SCAN_A = 4'd3;
  localparam logic [3:0] S_SCAN_B = 4'd4;
  localparam logic [3:0] S_EVAL   = 4'd5;
  localparam logic [3:0] S_SRCH_A = 4'd6;
  localparam logic [3:0] S_SRCH_B = 4'd7;

  logic [3:0]  state_r, state_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic        clr_emit_r, clr_emit_nxt;
  logic [30:0] request_id_r;
  logic [3:0]  retry_limit_r;
  logic [15:0] highest_r, highest_nxt;
  logic        any_acc_r, any_acc_nxt;
  logic [3:0]  tmo_r, tmo_nxt;
  logic        finished_r, finished_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] m_r, m_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] start0_r, start0_nxt;

  logic [15:0] pidx_r, plast_r, bytes_r;
  logic [31:0] start_r, stop_r;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  action_r, action_nxt;
  logic [5:0]  acc_part_r, acc_part_nxt;
  logic        rewritten_r, rewritten_nxt;
  logic [6:0]  from_part_r, from_part_nxt;
  logic [31:0] from_byte_r, from_byte_nxt;
  logic        end_valid_r, end_valid_nxt;
  logic [31:0] end_byte_r, end_byte_nxt;
  logic [31:0] tot_start_r, tot_start_nxt;
  logic [31:0] tot_size_r, tot_size_nxt;

  logic                in_accept;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  mrr_pkg::mrr_entry_t ram_wdata, ram_rdata;
  logic [3:0]          tmo_inc;
  logic                drop;
  logic [31:0]         base;

  assign busy      = (state_r != S_IDLE);
  assign in_accept = start & ~busy;
  assign cfg_ready = 1'b1;

  mrr_ram #(
    .WIDTH (mrr_pkg::ENTRY_W),
    .DEPTH (MAX_PARTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign tmo_inc = (tmo_r == mrr_pkg::TMO_MAX) ? tmo_r : tmo_r + 4'd1;
  assign drop    = !in_parse_ok || !in_name_ok || (in_packet_id != request_id_r) ||
                   (in_part_index >= 16'(MAX_PARTS));
  assign base    = (cur_r == '0) ? ram_rdata.start : start0_r;

  // Sequence the tracker through the part table
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    clr_emit_nxt  = clr_emit_r;
    highest_nxt   = highest_r;
    any_acc_nxt   = any_acc_r;
    tmo_nxt       = tmo_r;
    finished_nxt  = finished_r;
    cur_nxt       = cur_r;
    m_nxt         = m_r;
    sum_nxt       = sum_r;
    start0_nxt    = start0_r;
    out_valid_nxt = 1'b0;
    action_nxt    = mrr_pkg::ACT_NONE;
    acc_part_nxt  = '0;
    rewritten_nxt = 1'b0;
    from_part_nxt = '0;
    from_byte_nxt = '0;
    end_valid_nxt = 1'b0;
    end_byte_nxt  = '0;
    tot_start_nxt = '0;
    tot_size_nxt  = '0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = clr_emit_r;
          clr_emit_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_op == mrr_pkg::OP_BEGIN) begin
            highest_nxt  = '0;
            any_acc_nxt  = 1'b0;
            tmo_nxt      = '0;
            finished_nxt = 1'b0;
            clr_nxt      = '0;
            clr_emit_nxt = 1'b1;
            state_nxt    = S_CLR;
          end else if (finished_r ||
                       !(in_op inside {mrr_pkg::OP_PART, mrr_pkg::OP_TIMEOUT})) begin
            out_valid_nxt = 1'b1;
          end else if (in_op == mrr_pkg::OP_TIMEOUT) begin
            tmo_nxt       = tmo_inc;
            out_valid_nxt = 1'b1;
            if (tmo_inc >= retry_limit_r) begin
              finished_nxt = 1'b1;
              action_nxt   = mrr_pkg::ACT_FAILED;
            end else begin
              action_nxt = mrr_pkg::ACT_RESEND;
            end
          end else begin
            tmo_nxt = '0;
            if (drop) begin
              out_valid_nxt = 1'b1;
            end else if (!any_acc_r && in_part_last == '0) begin
              any_acc_nxt   = 1'b1;
              finished_nxt  = 1'b1;
              out_valid_nxt = 1'b1;
              action_nxt    = mrr_pkg::ACT_COMPLETE;
              acc_part_nxt  = in_part_index[5:0];
              tot_start_nxt = in_start_offset;
              tot_size_nxt  = in_stop_offset - in_start_offset;
            end else begin
              any_acc_nxt = 1'b1;
              ram_raddr   = in_part_index[IW-1:0];
              state_nxt   = S_DUP;
            end
          end
        end
      end
      S_DUP: begin
        if (ram_rdata.held) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = pidx_r[IW-1:0];
          ram_wdata.held  = 1'b1;
          ram_wdata.start = start_r;
          ram_wdata.stop  = stop_r;
          ram_wdata.size  = bytes_r;
          if (plast_r > highest_r) begin
            highest_nxt = plast_r;
          end
          cur_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_SCAN_A;
        end
      end
      S_SCAN_A: begin
        if (cur_r == CNT_MAX) begin
          state_nxt = S_EVAL;
        end else begin
          ram_raddr = cur_r[IW-1:0];
          state_nxt = S_SCAN_B;
        end
      end
      S_SCAN_B: begin
        if (ram_rdata.held) begin
          if (17'(cur_r) == {1'b0, highest_r}) begin
            finished_nxt  = 1'b1;
            out_valid_nxt = 1'b1;
            action_nxt    = mrr_pkg::ACT_COMPLETE;
            acc_part_nxt  = pidx_r[5:0];
            tot_start_nxt = base;
            tot_size_nxt  = ram_rdata.stop - base;
            state_nxt     = S_IDLE;
          end else begin
            sum_nxt    = sum_r + 32'(ram_rdata.size);
            start0_nxt = base;
            cur_nxt    = cur_r + 1'b1;
            state_nxt  = S_SCAN_A;
          end
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (cur_r == '0) begin
          out_valid_nxt = 1'b1;
          action_nxt    = mrr_pkg::ACT_ACCEPTED;
          acc_part_nxt  = pidx_r[5:0];
          state_nxt     = S_IDLE;
        end else begin
          m_nxt     = cur_r + 1'b1;
          state_nxt = S_SRCH_A;
        end
      end
      S_SRCH_A: begin
        if (m_r >= CNT_MAX || 17'(m_r) >= {1'b0, highest_r}) begin
          out_valid_nxt = 1'b1;
          action_nxt    = mrr_pkg::ACT_ACCEPTED;
          acc_part_nxt  = pidx_r[5:0];
          rewritten_nxt = 1'b1;
          from_part_nxt = 7'(cur_r);
          from_byte_nxt = sum_r;
          state_nxt     = S_IDLE;
        end else begin
          ram_raddr = m_r[IW-1:0];
          state_nxt = S_SRCH_B;
        end
      end
      S_SRCH_B: begin
        if (ram_rdata.held) begin
          out_valid_nxt = 1'b1;
          action_nxt    = mrr_pkg::ACT_ACCEPTED;
          acc_part_nxt  = pidx_r[5:0];
          rewritten_nxt = 1'b1;
          from_part_nxt = 7'(cur_r);
          from_byte_nxt = sum_r;
          end_valid_nxt = 1'b1;
          end_byte_nxt  = ram_rdata.start;
          state_nxt     = S_IDLE;
        end else begin
          m_nxt     = m_r + 1'b1;
          state_nxt = S_SRCH_A;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts a clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      clr_emit_r  <= 1'b0;
      highest_r   <= '0;
      any_acc_r   <= 1'b0;
      tmo_r       <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_emit_r  <= clr_emit_nxt;
      highest_r   <= highest_nxt;
      any_acc_r   <= any_acc_nxt;
      tmo_r       <= tmo_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_id_r  <= '0;
      retry_limit_r <= mrr_pkg::RETRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mrr_pkg::REG_REQUEST_ID:  request_id_r  <= cfg_data[30:0];
        mrr_pkg::REG_RETRY_LIMIT: retry_limit_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pidx_r  <= in_part_index;
      plast_r <= in_part_last;
      start_r <= in_start_offset;
      stop_r  <= in_stop_offset;
      bytes_r <= in_part_bytes;
    end
    cur_r       <= cur_nxt;
    m_r         <= m_nxt;
    sum_r       <= sum_nxt;
    start0_r    <= start0_nxt;
    action_r    <= action_nxt;
    acc_part_r  <= acc_part_nxt;
    rewritten_r <= rewritten_nxt;
    from_part_r <= from_part_nxt;
    from_byte_r <= from_byte_nxt;
    end_valid_r <= end_valid_nxt;
    end_byte_r  <= end_byte_nxt;
    tot_start_r <= tot_start_nxt;
    tot_size_r  <= tot_size_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_action            = action_r;
  assign out_accepted_part     = acc_part_r;
  assign out_request_rewritten = rewritten_r;
  assign out_from_part         = from_part_r;
  assign out_from_byte         = from_byte_r;
  assign out_end_valid         = end_valid_r;
  assign out_end_byte          = end_byte_r;
  assign out_total_start       = tot_start_r;
  assign out_total_size        = tot_size_r;

  // A rewritten range only accompanies an accepted part
  a_rewrite_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_rewritten |-> out_action == mrr_pkg::ACT_ACCEPTED)
    else $error("rewrite without accepted action");

  // An end bound needs a rewritten range
  a_end_needs_rewrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_valid |-> out_request_rewritten)
    else $error("end bound without rewrite");

  // Completion and failure leave the tracker finished
  a_finish_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == mrr_pkg::ACT_COMPLETE ||
                  out_action == mrr_pkg::ACT_FAILED) |-> finished_r)
    else $error("terminal result without finished state");

  // A result always follows work of the previous cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result without an item");

endmodule
